// ===== rtl/mms_pkg.sv =====
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types and constants of the min/max stack: beat layouts of the
// input and result channels, operation and status codes, default sizes.
// ----------------------------------------------------------------------------
package mms_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned FieldWidth = 32;
  localparam int unsigned DepthWidth = 7;

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    op_e                           opcode;
    logic signed [FieldWidth-1:0]  push_value;
  } in_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0]  top_value;
    logic signed [FieldWidth-1:0]  min_value;
    logic signed [FieldWidth-1:0]  max_value;
    logic        [DepthWidth-1:0]  depth_used;
    logic                          is_empty;
    status_e                       status;
  } out_t;

endpackage

// ===== rtl/mms_mem.sv =====
// ----------------------------------------------------------------------------
// mms_mem
// Single-port-write, single-port-read synchronous memory holding one stack
// level per entry. Read data is registered.
// ----------------------------------------------------------------------------
module mms_mem #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 96
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/min_max_stack.sv =====
// ----------------------------------------------------------------------------
// min_max_stack
// Bounded LIFO stack of signed words that tracks the running minimum and
// maximum. Each level holds its value with the minimum and maximum of all
// levels at or below it; the top level is mirrored in a register.
//
//   channel  | direction | handshake             | beat
//   in       | input     | in_valid_i/in_stall_o | mms_pkg::in_t
//   out      | output    | out_valid_o/out_stall_i | mms_pkg::out_t
//
// A push, a rejected push, a rejected pop and a pop that empties the stack
// are answered from the idle state; a pop that leaves one or more elements
// passes through the pop state, waiting on the memory read of the new top
// level. Reset empties the stack at once; the memory needs no clearing. The
// output register takes a result whenever it is empty or being drained, so
// a new beat is accepted while the previous result is handed over.
// ----------------------------------------------------------------------------
module min_max_stack #(
  parameter int unsigned STACK_DEPTH = mms_pkg::StackDepth,
  parameter int unsigned DATA_WIDTH  = mms_pkg::DataWidth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mms_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mms_pkg::out_t out_data_o
);

  import mms_pkg::*;

  localparam int unsigned AddrWidth  = $clog2(STACK_DEPTH);
  localparam int unsigned CountWidth = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] val;
    logic signed [DATA_WIDTH-1:0] mn;
    logic signed [DATA_WIDTH-1:0] mx;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [CountWidth-1:0]   count_q, count_d;
  entry_t                  top_q, top_d;
  out_t                    out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                    in_acc;
  logic                    out_free;
  logic                    is_full;
  logic                    is_zero;
  logic signed [DATA_WIDTH-1:0] push_v;
  entry_t                  push_e;
  logic                    wr_en;
  logic                    rd_en;
  logic [AddrWidth-1:0]    rd_addr;
  logic [3*DATA_WIDTH-1:0] rd_data;
  entry_t                  rd_e;

  function automatic out_t make_out(entry_t e, logic [CountWidth-1:0] cnt, status_e st);
    out_t o;
    o.depth_used = DepthWidth'(cnt);
    o.status     = st;
    if (cnt == '0) begin
      o.top_value = '0;
      o.min_value = '0;
      o.max_value = '0;
      o.is_empty  = 1'b1;
    end else begin
      o.top_value = FieldWidth'(e.val);
      o.min_value = FieldWidth'(e.mn);
      o.max_value = FieldWidth'(e.mx);
      o.is_empty  = 1'b0;
    end
    return o;
  endfunction

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign is_full = (count_q == CountWidth'(STACK_DEPTH));
  assign is_zero = (count_q == '0);

  assign push_v     = DATA_WIDTH'(in_data_i.push_value);
  assign push_e.val = push_v;
  assign push_e.mn  = (is_zero || push_v < top_q.mn) ? push_v : top_q.mn;
  assign push_e.mx  = (is_zero || top_q.mx < push_v) ? push_v : top_q.mx;

  assign wr_en   = in_acc && (in_data_i.opcode == OP_PUSH) && !is_full;
  assign rd_en   = in_acc && (in_data_i.opcode == OP_POP) && (count_q > CountWidth'(1));
  assign rd_addr = AddrWidth'(count_q - CountWidth'(2));
  assign rd_e    = entry_t'(rd_data);

  mms_mem #(
    .Depth (STACK_DEPTH),
    .Width (3 * DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrWidth-1:0]),
    .wr_data_i (push_e),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    top_d       = top_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.opcode)
            OP_PUSH: begin
              if (is_full) begin
                out_d = make_out(top_q, count_q, ST_OVERFLOW);
              end else begin
                top_d   = push_e;
                count_d = count_q + CountWidth'(1);
                out_d   = make_out(push_e, count_q + CountWidth'(1), ST_OK);
              end
              out_valid_d = 1'b1;
            end
            OP_POP: begin
              if (is_zero) begin
                out_d       = make_out(top_q, count_q, ST_UNDERFLOW);
                out_valid_d = 1'b1;
              end else begin
                count_d = count_q - CountWidth'(1);
                if (rd_en) begin
                  state_d = S_POP;
                end else begin
                  out_d       = make_out(top_q, '0, ST_OK);
                  out_valid_d = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        top_d       = rd_e;
        out_d       = make_out(rd_e, count_q, ST_OK);
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/mms_checker.sv =====
// ----------------------------------------------------------------------------
// mms_checker
// Port-level checks of the min/max stack: result beats hold while stalled,
// an empty stack reports zero values, a non-empty stack keeps its top value
// between its minimum and maximum, and every accepted pop gets a result.
// ----------------------------------------------------------------------------
module mms_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_o,
  input  mms_pkg::in_t  in_data_i,
  input  logic          out_valid_o,
  input  logic          out_stall_i,
  input  mms_pkg::out_t out_data_o
);

  import mms_pkg::*;

  logic in_beat;

  assign in_beat = in_valid_i && !in_stall_o && (in_data_i.opcode == OP_POP);

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result beat dropped while stalled.");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("Result beat changed while stalled.");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |->
      out_data_o.top_value == '0 && out_data_o.min_value == '0 &&
      out_data_o.max_value == '0 && out_data_o.status != ST_OVERFLOW)
    else $error("Empty stack reported non-zero values.");

  a_top_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.is_empty |->
      out_data_o.min_value <= out_data_o.top_value &&
      out_data_o.top_value <= out_data_o.max_value &&
      out_data_o.status != ST_UNDERFLOW)
    else $error("Top value lies outside the reported minimum and maximum.");

  a_pop_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> ##[1:2] out_valid_o)
    else $error("Pop gave no result within two cycles.");

endmodule

bind min_max_stack mms_checker u_mms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
